/* rtl/core/one_shot_timer_bank_defines.svh */
// Assertion helpers used by the checker file.
`ifndef ONE_SHOT_TIMER_BANK_DEFINES_SVH
`define ONE_SHOT_TIMER_BANK_DEFINES_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define OSTB_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define OSTB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/ostb_pkg.sv */
package ostb_pkg;

   localparam int unsigned MODE_WIDTH  = 3;
   localparam int unsigned ID_WIDTH    = 3;
   localparam int unsigned COUNT_WIDTH = 32;
   localparam int unsigned STATE_WIDTH = 2;
   localparam int unsigned MASK_WIDTH  = 8;
   localparam int unsigned NUM_IDS     = 2 ** ID_WIDTH;

   // command codes
   localparam logic [MODE_WIDTH-1:0] MODE_TICK    = 3'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_CREATE  = 3'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_CONTROL = 3'd2;
   localparam logic [MODE_WIDTH-1:0] MODE_DELETE  = 3'd3;
   localparam logic [MODE_WIDTH-1:0] MODE_RESET   = 3'd4;
   localparam logic [MODE_WIDTH-1:0] MODE_GET     = 3'd5;

   // get-state answers
   localparam logic [STATE_WIDTH-1:0] ST_STOPPED = 2'd0;
   localparam logic [STATE_WIDTH-1:0] ST_RUNNING = 2'd1;
   localparam logic [STATE_WIDTH-1:0] ST_INVALID = 2'd2;

   typedef struct packed {
      logic [MODE_WIDTH-1:0]  mode;
      logic [ID_WIDTH-1:0]    timer_id;
      logic [COUNT_WIDTH-1:0] period;
      logic                   run_request;
      logic                   has_action;
   } req_type;

   typedef struct packed {
      logic                   status;
      logic [STATE_WIDTH-1:0] timer_state;
      logic [MASK_WIDTH-1:0]  fired_mask;
   } rsp_type;

   // broadcast to every slot for the item being executed
   typedef struct packed {
      logic                   tick;
      logic                   create;
      logic                   control;
      logic                   remove;
      logic                   restart;
      logic                   run_request;
      logic                   has_action;
      logic [COUNT_WIDTH-1:0] period;
   } slot_cmd_type;

   typedef struct packed {
      logic valid;
      logic running;
      logic fired;
   } slot_stat_type;

endpackage

/* rtl/core/ostb_slot.sv */
module ostb_slot import ostb_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  slot_cmd_type  cmd,
   input  logic          hit,
   output slot_stat_type stat
);

   logic                   valid_ff, valid_in;
   logic                   running_ff, running_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [COUNT_WIDTH-1:0] period_ff, period_in;

   logic [COUNT_WIDTH-1:0] count_inc;
   logic                   active;
   logic                   expire;

   // saturating increment
   assign count_inc = (count_ff == '1) ? count_ff : count_ff + 1'b1;
   assign expire    = (count_inc >= period_ff);
   assign active    = valid_ff && running_ff;

   always_comb begin
      valid_in   = valid_ff;
      running_in = running_ff;
      count_in   = count_ff;
      period_in  = period_ff;
      if (cmd.tick && active) begin
         count_in = count_inc;
         if (expire) begin
            running_in = 1'b0;
         end
      end
      if (hit) begin
         priority if (cmd.create) begin
            valid_in   = cmd.has_action;
            running_in = cmd.run_request;
            count_in   = '0;
            period_in  = cmd.period;
         end else if (cmd.control && valid_ff) begin
            running_in = cmd.run_request;
         end else if (cmd.remove && valid_ff) begin
            valid_in   = 1'b0;
            running_in = 1'b0;
            count_in   = '0;
            period_in  = '0;
         end else if (cmd.restart && valid_ff) begin
            running_in = cmd.run_request;
            count_in   = '0;
         end else begin
            // tick, get, empty slot or no command this cycle: hit makes no change
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         running_ff <= 1'b0;
         count_ff   <= '0;
         period_ff  <= '0;
      end else begin
         valid_ff   <= valid_in;
         running_ff <= running_in;
         count_ff   <= count_in;
         period_ff  <= period_in;
      end
   end

   assign stat.valid   = valid_ff;
   assign stat.running = running_ff;
   assign stat.fired   = cmd.tick && active && expire;

endmodule

/* rtl/core/one_shot_timer_bank.sv */
// Channel  Dir  Handshake              Payload
// req      in   req_valid / req_ready  req_data  (req_type: command, slot, period, flags)
// rsp      out  rsp_valid / rsp_ready  rsp_data  (rsp_type: status, state, fired mask)
//
// One transfer in, one transfer out per command, in order.
// A command passes the input register, then slot update and result register.
// Sustains one command per cycle while rsp is not stalled; the slot array is
// read and written in the same cycle the command leaves the input register.
// Synchronous active-high reset clears every slot and both valid flags.
// A stalled rsp holds the command in the input register; req_ready drops only
// when both stages are full.
module one_shot_timer_bank import ostb_pkg::*; #(
   parameter int unsigned NUM_TIMERS = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // input stage
   logic    item_valid_ff, item_valid_in;
   req_type item_ff;

   // result stage
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // command executes when it leaves the input register
   logic advance;

   slot_cmd_type             cmd;
   slot_stat_type            stat [NUM_TIMERS];
   logic [NUM_TIMERS-1:0]    hit_vec;
   logic [NUM_TIMERS-1:0]    valid_vec;
   logic [NUM_TIMERS-1:0]    running_vec;
   logic [NUM_TIMERS-1:0]    fired_vec;
   logic [MASK_WIDTH-1:0]    fired_mask;
   logic                     live;
   logic                     sel_running;

   assign advance   = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || advance;

   assign item_valid_in = req_ready ? req_valid : item_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_data;
      end
   end

   // command broadcast; slot decode happens per slot via hit_vec
   always_comb begin
      cmd.tick        = advance && (item_ff.mode == MODE_TICK);
      cmd.create      = advance && (item_ff.mode == MODE_CREATE);
      cmd.control     = advance && (item_ff.mode == MODE_CONTROL);
      cmd.remove      = advance && (item_ff.mode == MODE_DELETE);
      cmd.restart     = advance && (item_ff.mode == MODE_RESET);
      cmd.run_request = item_ff.run_request;
      cmd.has_action  = item_ff.has_action;
      cmd.period      = item_ff.period;
   end

   for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_slot
      // slots past the id range are reachable by ticks only
      if (i < NUM_IDS) begin : g_addr
         assign hit_vec[i] = (item_ff.timer_id == ID_WIDTH'(i));
      end else begin : g_noaddr
         assign hit_vec[i] = 1'b0;
      end

      ostb_slot u_slot (
         .clock (clock),
         .reset (reset),
         .cmd   (cmd),
         .hit   (hit_vec[i]),
         .stat  (stat[i])
      );

      assign valid_vec[i]   = stat[i].valid;
      assign running_vec[i] = stat[i].running;
      assign fired_vec[i]   = stat[i].fired;
   end

   // only the low slots have a mask bit
   for (genvar b = 0; b < MASK_WIDTH; b++) begin : g_mask
      if (b < NUM_TIMERS) begin : g_bit
         assign fired_mask[b] = fired_vec[b];
      end else begin : g_zero
         assign fired_mask[b] = 1'b0;
      end
   end

   // hit_vec is at most one-hot, so an OR-reduce selects the slot
   assign live        = |(hit_vec & valid_vec);
   assign sel_running = |(hit_vec & running_vec);

   always_comb begin
      rsp_in = '0;
      unique case (item_ff.mode)
         MODE_TICK: begin
            rsp_in.fired_mask = fired_mask;
         end
         MODE_CONTROL, MODE_DELETE, MODE_RESET: begin
            rsp_in.status = !live;
         end
         MODE_GET: begin
            if (live) begin
               rsp_in.timer_state = sel_running ? ST_RUNNING : ST_STOPPED;
            end else begin
               rsp_in.timer_state = ST_INVALID;
            end
         end
         default: begin
            // create and unused codes answer all zero
            rsp_in = '0;
         end
      endcase
   end

   assign rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* rtl/core/ostb_checker.sv */
`include "one_shot_timer_bank_defines.svh"

module ostb_checker import ostb_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   logic req_stall;
   logic rsp_stall;
   logic state_reply;
   logic others_clear;

   assign req_stall    = req_valid && !req_ready;
   assign rsp_stall    = rsp_valid && !rsp_ready;
   assign state_reply  = rsp_valid && (rsp_data.timer_state != ST_STOPPED);
   assign others_clear = (rsp_data.fired_mask == '0) && !rsp_data.status;

   `OSTB_ASSERT_NEXT(a_req_hold, req_stall, req_valid && $stable(req_data), "req not held")

   `OSTB_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_data), "rsp not held")

   `OSTB_ASSERT_NOW(a_ready_when_empty, !rsp_valid, req_ready, "req stalled, rsp empty")

   `OSTB_ASSERT_NOW(a_state_excl, state_reply, others_clear, "state answer mixed")

   `OSTB_ASSERT_NOW(a_reset_idle, $past(reset), !rsp_valid, "rsp valid after reset")

endmodule

bind one_shot_timer_bank ostb_checker u_ostb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
